// ----- design/direct_mapped_write_through_cache_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the direct-mapped write-through cache
// Immediate-style wrappers around concurrent assertions; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_WRITE_THROUGH_CACHE_DEFINES_SVH
`define DIRECT_MAPPED_WRITE_THROUGH_CACHE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset
`define DMWTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmwtc assertion failed");

// Next-cycle implication, checked out of reset
`define DMWTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmwtc assertion failed");

`else

`define DMWTC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DMWTC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/dmwtc_pkg.sv -----
// ----------------------------------------------------------------------------
// dmwtc_pkg
// Sizes, address split, field types and sequencer states of the cache.
// ----------------------------------------------------------------------------
package dmwtc_pkg;

    // Geometry
    localparam int NUM_LINES      = 8;
    localparam int WORDS_PER_LINE = 4;
    localparam int MEM_WORDS      = 4096;
    localparam int DATA_W         = 32;

    // Field widths
    localparam int ADDR_W  = 12;
    localparam int COUNT_W = 16;

    // Address split
    localparam int OFFS_W = $clog2(WORDS_PER_LINE);
    localparam int IDX_W  = $clog2(NUM_LINES);
    localparam int MEM_AW = $clog2(MEM_WORDS);
    localparam int TAG_W  = MEM_AW - IDX_W - OFFS_W;
    localparam int SLOT_W = IDX_W + OFFS_W;
    localparam int SLOTS  = NUM_LINES * WORDS_PER_LINE;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [MEM_AW-1:0]  MEM_LAST  = MEM_AW'(MEM_WORDS - 1);
    localparam logic [OFFS_W-1:0]  OFFS_LAST = OFFS_W'(WORDS_PER_LINE - 1);

    // Request codes
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef logic        [ADDR_W-1:0]  addr_t;
    typedef logic signed [DATA_W-1:0]  data_t;
    typedef logic        [COUNT_W-1:0] count_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_ACCESS,
        ST_DONE
    } state_t;

endpackage

// ----- design/dmwtc_req_if.sv -----
// ----------------------------------------------------------------------------
// dmwtc_req_if
// Request channel: one cache access per transfer.
// ----------------------------------------------------------------------------
interface dmwtc_req_if;
    import dmwtc_pkg::*;

    logic  valid;
    logic  ready;
    logic  req_type;
    addr_t address;
    data_t write_data;

    modport source (output valid, output req_type, output address, output write_data,
                    input ready);
    modport sink   (input valid, input req_type, input address, input write_data,
                    output ready);
endinterface

// ----- design/dmwtc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dmwtc_rsp_if
// Response channel: one result per accepted access.
// ----------------------------------------------------------------------------
interface dmwtc_rsp_if;
    import dmwtc_pkg::*;

    logic   valid;
    logic   ready;
    logic   hit;
    data_t  read_data;
    count_t hit_count;
    count_t miss_count;

    modport source (output valid, output hit, output read_data, output hit_count,
                    output miss_count, input ready);
    modport sink   (input valid, input hit, input read_data, input hit_count,
                    input miss_count, output ready);
endinterface

// ----- design/dmwtc_ram.sv -----
// ----------------------------------------------------------------------------
// dmwtc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dmwtc_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/direct_mapped_write_through_cache.sv -----
// ----------------------------------------------------------------------------
// direct_mapped_write_through_cache
// Direct-mapped write-through cache in front of a word-addressed backing RAM.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all MEM_WORDS (4096) backing
// words that loads each with its own address; req.ready stays low during it.
// Then one access is handled at a time by a small sequencer around a
// single-port-per-side line RAM and backing RAM. A hit goes from transfer to
// result through lookup, RAM access and registered read data. A miss first
// refills the line, a backing RAM read and then a line RAM write for each of
// its WORDS_PER_LINE words, as the one backing RAM read port moves a single
// word per read. The result waits in an output register, so a new request is
// taken while the previous result is still unclaimed. Writes always go through
// to the backing RAM and allocate the line on a miss; only reads move the hit
// and miss counters, which saturate.
// ----------------------------------------------------------------------------
`include "direct_mapped_write_through_cache_defines.svh"

module direct_mapped_write_through_cache (
    input  logic        clk,
    input  logic        rst_n,
    dmwtc_req_if.sink   req,
    dmwtc_rsp_if.source rsp
);
    import dmwtc_pkg::*;

    // Sequencer and counters
    state_t              state_reg, state_next;
    logic [MEM_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [OFFS_W-1:0]   fill_cnt_reg, fill_cnt_next;
    count_t              hit_cnt_reg, hit_cnt_next;
    count_t              miss_cnt_reg, miss_cnt_next;

    // Latched request
    logic                req_type_reg;
    logic [MEM_AW-1:0]   addr_reg;
    data_t               wdata_reg;
    logic                hit_reg;

    // Tag store
    logic [TAG_W-1:0]    tag_reg [NUM_LINES];
    logic [NUM_LINES-1:0] valid_reg;

    // Output register
    logic                out_valid_reg;
    logic                out_hit_reg;
    data_t               out_data_reg;
    count_t              out_hits_reg;
    count_t              out_misses_reg;

    // Address split of the latched request
    logic [TAG_W-1:0]    cur_tag;
    logic [IDX_W-1:0]    cur_idx;
    logic [OFFS_W-1:0]   cur_offs;
    logic                line_hit;

    // RAM hookup
    logic                mem_we, mem_re;
    logic [MEM_AW-1:0]   mem_waddr, mem_raddr;
    logic [DATA_W-1:0]   mem_wdata, mem_rdata;
    logic                line_we, line_re;
    logic [SLOT_W-1:0]   line_waddr, line_raddr;
    logic [DATA_W-1:0]   line_wdata, line_rdata;

    logic                req_xfer;
    logic                done_load;

    assign cur_offs = addr_reg[OFFS_W-1:0];
    assign cur_idx  = addr_reg[OFFS_W +: IDX_W];
    assign cur_tag  = addr_reg[MEM_AW-1 -: TAG_W];
    assign line_hit = valid_reg[cur_idx] && (tag_reg[cur_idx] == cur_tag);

    assign req_xfer  = req.valid && req.ready;
    assign done_load = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == MEM_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = line_hit ? ST_ACCESS : ST_FILL_RD;
            end
            ST_FILL_RD:
            begin
                state_next = ST_FILL_WR;
            end
            ST_FILL_WR:
            begin
                state_next = (fill_cnt_reg == OFFS_LAST) ? ST_ACCESS : ST_FILL_RD;
            end
            ST_ACCESS:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (done_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Sequencer outputs: RAM controls and counter updates
    always_comb
    begin
        req.ready     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = DATA_W'(wdata_reg);
        mem_re        = 1'b0;
        mem_raddr     = {cur_tag, cur_idx, fill_cnt_reg};
        line_we       = 1'b0;
        line_waddr    = {cur_idx, fill_cnt_reg};
        line_wdata    = mem_rdata;
        line_re       = 1'b0;
        line_raddr    = {cur_idx, cur_offs};
        clr_cnt_next  = clr_cnt_reg;
        fill_cnt_next = fill_cnt_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = DATA_W'(clr_cnt_reg);
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_CHECK:
            begin
                fill_cnt_next = '0;
            end
            ST_FILL_RD:
            begin
                mem_re = 1'b1;
            end
            ST_FILL_WR:
            begin
                line_we       = 1'b1;
                fill_cnt_next = fill_cnt_reg + 1'b1;
            end
            ST_ACCESS:
            begin
                if (req_type_reg == REQ_WRITE)
                begin
                    mem_we     = 1'b1;
                    line_we    = 1'b1;
                    line_waddr = {cur_idx, cur_offs};
                    line_wdata = DATA_W'(wdata_reg);
                end
                else
                begin
                    line_re = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (done_load && (req_type_reg == REQ_READ))
                begin
                    if (hit_reg)
                    begin
                        if (hit_cnt_reg != COUNT_MAX)
                        begin
                            hit_cnt_next = hit_cnt_reg + 1'b1;
                        end
                    end
                    else if (miss_cnt_reg != COUNT_MAX)
                    begin
                        miss_cnt_next = miss_cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            fill_cnt_reg <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            fill_cnt_reg <= fill_cnt_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
        end
    end

    // Tag store: allocate on any miss
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else if ((state_reg == ST_CHECK) && !line_hit)
        begin
            valid_reg[cur_idx] <= 1'b1;
            tag_reg[cur_idx]   <= cur_tag;
        end
    end

    // Request capture and lookup result
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            req_type_reg <= req.req_type;
            addr_reg     <= MEM_AW'(req.address);
            wdata_reg    <= req.write_data;
        end
        if (state_reg == ST_CHECK)
        begin
            hit_reg <= line_hit;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_load)
        begin
            out_hit_reg    <= hit_reg;
            out_data_reg   <= (req_type_reg == REQ_WRITE) ? wdata_reg : data_t'(line_rdata);
            out_hits_reg   <= hit_cnt_next;
            out_misses_reg <= miss_cnt_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.read_data  = out_data_reg;
    assign rsp.hit_count  = out_hits_reg;
    assign rsp.miss_count = out_misses_reg;

    // Backing memory
    dmwtc_ram #(
        .DEPTH (MEM_WORDS),
        .WIDTH (DATA_W)
    ) u_backing_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Cached line words
    dmwtc_ram #(
        .DEPTH (SLOTS),
        .WIDTH (DATA_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .re    (line_re),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // Checks
    `DMWTC_ASSERT_NXT(a_xfer_to_check, clk, rst_n, req_xfer, state_reg == ST_CHECK)
    `DMWTC_ASSERT_NXT(a_miss_starts_fill, clk, rst_n, (state_reg == ST_CHECK) && !line_hit, (state_reg == ST_FILL_RD) && (fill_cnt_reg == '0) && valid_reg[cur_idx])
    `DMWTC_ASSERT_NXT(a_counters_monotone, clk, rst_n, 1'b1, (hit_cnt_reg >= $past(hit_cnt_reg)) && (miss_cnt_reg >= $past(miss_cnt_reg)))
    `DMWTC_ASSERT_IMP(a_write_no_count, clk, rst_n, (state_reg == ST_DONE) && (req_type_reg == REQ_WRITE), (hit_cnt_next == hit_cnt_reg) && (miss_cnt_next == miss_cnt_reg))

endmodule
